// ===== sv/wgbf_pkg.sv =====
package wgbf_pkg;

    localparam int HALF_FFT_DEF = 128;
    localparam int BIN_W        = 8;
    localparam int SMP_W        = 16;
    localparam int PWR_W        = 32;
    localparam int GAIN_W       = 16;
    localparam int DIV_STEPS    = GAIN_W;

    localparam logic [1:0] REG_ALPHA = 2'd0;
    localparam logic [1:0] REG_FLOOR = 2'd1;
    localparam logic [1:0] REG_BETA  = 2'd2;
    localparam logic [1:0] REG_NUE   = 2'd3;

    localparam logic [15:0] ALPHA_RST = 16'd58982;
    localparam logic [31:0] FLOOR_RST = 32'd0;
    localparam logic [15:0] BETA_RST  = 16'd256;
    localparam logic        NUE_RST   = 1'b1;

    typedef struct packed {
        logic [15:0] alpha;
        logic [31:0] floor;
        logic [15:0] beta;
        logic        nue;
    } cfg_t;

    typedef struct packed {
        logic [BIN_W-1:0]        bin;
        logic signed [SMP_W-1:0] tre;
        logic signed [SMP_W-1:0] tim;
        logic                    pass;
    } meta_t;

endpackage

// ===== sv/wgbf_psd.sv =====
module wgbf_psd import wgbf_pkg::*; #(
    parameter int HALF_FFT = HALF_FFT_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  meta_t                   in_meta,
    input  logic signed [SMP_W-1:0] in_nre,
    input  logic signed [SMP_W-1:0] in_nim,
    input  cfg_t                    cfg,
    output logic                    out_valid,
    output meta_t                   out_meta,
    output logic [PWR_W-1:0]        out_psds,
    output logic [PWR_W-1:0]        out_psdn
);

    localparam int DEPTH = HALF_FFT + 1;
    localparam int AW    = $clog2(DEPTH);

    function automatic logic [PWR_W-1:0] smooth(logic [15:0] a, logic [PWR_W-1:0] prev,
                                                logic [PWR_W-1:0] curr);
        logic signed [32:0] d;
        logic signed [49:0] p;
        logic [50:0]        s;
        d = $signed({1'b0, prev}) - $signed({1'b0, curr});
        p = 50'($signed({1'b0, a})) * 50'(d);
        s = {3'b0, curr, 16'h0} + {p[49], p} + 51'd32768;
        return s[47:16];
    endfunction

    logic [PWR_W-1:0] mem_s [0:DEPTH-1];
    logic [PWR_W-1:0] mem_n [0:DEPTH-1];
    logic [DEPTH-1:0] vld_s_reg;
    logic [DEPTH-1:0] vld_n_reg;
    logic             first_reg;

    logic signed [31:0] tr_w, ti_w, nr_w, ni_w;
    logic [AW-1:0]      addr_in;

    logic             v1_reg;
    meta_t            meta1_reg;
    logic [AW-1:0]    addr1_reg;
    logic [31:0]      sq_tr1_reg, sq_ti1_reg, sq_nr1_reg, sq_ni1_reg;
    logic [PWR_W-1:0] rd_s1_reg, rd_n1_reg;
    logic             rv_s1_reg, rv_n1_reg;

    logic             v2_reg;
    meta_t            meta2_reg;
    logic [AW-1:0]    addr2_reg;
    logic [PWR_W-1:0] cs2_reg, cn2_reg, ps2_reg, pn2_reg;

    logic             v3_reg;
    meta_t            meta3_reg;
    logic [AW-1:0]    addr3_reg;
    logic             nwr3_reg;
    logic [PWR_W-1:0] psds3_reg, psdn3_reg;

    logic [PWR_W-1:0] pwr_s, pwr_n, pwr_nf, prev_s1, prev_n1;
    logic [PWR_W-1:0] prev_s2, prev_n2, psds2, psdn2;
    logic [15:0]      a2;
    logic             upd2, upd3;

    assign tr_w    = 32'(in_meta.tre);
    assign ti_w    = 32'(in_meta.tim);
    assign nr_w    = 32'(in_nre);
    assign ni_w    = 32'(in_nim);
    assign addr_in = in_meta.pass ? '0 : AW'(in_meta.bin);

    assign upd2 = v2_reg && !meta2_reg.pass;
    assign upd3 = v3_reg && !meta3_reg.pass;

    // stage 1: powers, forward from the item written as this one read
    assign pwr_s  = sq_tr1_reg + sq_ti1_reg;
    assign pwr_n  = sq_nr1_reg + sq_ni1_reg;
    assign pwr_nf = (pwr_n < cfg.floor) ? cfg.floor : pwr_n;
    assign prev_s1 = (upd3 && addr3_reg == addr1_reg) ? psds3_reg :
                     (rv_s1_reg ? rd_s1_reg : '0);
    assign prev_n1 = (upd3 && nwr3_reg && addr3_reg == addr1_reg) ? psdn3_reg :
                     (rv_n1_reg ? rd_n1_reg : '0);

    // stage 2: smoothing, forward from the item one ahead
    assign a2      = first_reg ? 16'd0 : cfg.alpha;
    assign prev_s2 = (upd3 && addr3_reg == addr2_reg) ? psds3_reg : ps2_reg;
    assign prev_n2 = (upd3 && nwr3_reg && addr3_reg == addr2_reg) ? psdn3_reg : pn2_reg;
    assign psds2   = smooth(a2, prev_s2, cs2_reg);
    assign psdn2   = cfg.nue ? smooth(a2, prev_n2, cn2_reg) : prev_n2;

    always_ff @(posedge aclk) begin
        if (en) begin
            rd_s1_reg <= mem_s[addr_in];
            rd_n1_reg <= mem_n[addr_in];
            if (upd2) begin
                mem_s[addr2_reg] <= psds2;
                if (cfg.nue) begin
                    mem_n[addr2_reg] <= psdn2;
                end
            end
            meta1_reg  <= in_meta;
            addr1_reg  <= addr_in;
            sq_tr1_reg <= tr_w * tr_w;
            sq_ti1_reg <= ti_w * ti_w;
            sq_nr1_reg <= nr_w * nr_w;
            sq_ni1_reg <= ni_w * ni_w;
            meta2_reg  <= meta1_reg;
            addr2_reg  <= addr1_reg;
            cs2_reg    <= pwr_s;
            cn2_reg    <= pwr_nf;
            ps2_reg    <= prev_s1;
            pn2_reg    <= prev_n1;
            meta3_reg  <= meta2_reg;
            addr3_reg  <= addr2_reg;
            nwr3_reg   <= cfg.nue;
            psds3_reg  <= psds2;
            psdn3_reg  <= psdn2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_s_reg <= '0;
            vld_n_reg <= '0;
            first_reg <= 1'b1;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            rv_s1_reg <= 1'b0;
            rv_n1_reg <= 1'b0;
        end else if (en) begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            rv_s1_reg <= vld_s_reg[addr_in];
            rv_n1_reg <= vld_n_reg[addr_in];
            if (upd2) begin
                vld_s_reg[addr2_reg] <= 1'b1;
                if (cfg.nue) begin
                    vld_n_reg[addr2_reg] <= 1'b1;
                end
                if (32'(meta2_reg.bin) == HALF_FFT) begin
                    first_reg <= 1'b0;
                end
            end
        end
    end

    assign out_valid = v3_reg;
    assign out_meta  = meta3_reg;
    assign out_psds  = psds3_reg;
    assign out_psdn  = psdn3_reg;

endmodule

// ===== sv/wgbf_gain.sv =====
module wgbf_gain import wgbf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  meta_t             in_meta,
    input  logic [PWR_W-1:0]  in_psds,
    input  logic [PWR_W-1:0]  in_psdn,
    input  logic [15:0]       beta,
    output logic              out_valid,
    output meta_t             out_meta,
    output logic [GAIN_W-1:0] out_gain
);

    localparam int N  = DIV_STEPS;
    localparam int DW = PWR_W + 17;

    logic [47:0]    bn;
    logic [DW-1:0]  den_in;

    logic              v_reg    [0:N];
    meta_t             meta_reg [0:N];
    logic [DW-1:0]     den_reg  [0:N];
    logic [DW-1:0]     rem_reg  [0:N];
    logic [GAIN_W-1:0] q_reg    [0:N];
    logic              zbn_reg  [0:N];
    logic              psz_reg  [0:N];

    logic [DW:0]       sh   [0:N-1];
    logic              ge   [0:N-1];
    logic [DW-1:0]     rem_next [0:N-1];

    assign bn     = 48'(beta) * 48'(in_psdn);
    assign den_in = {9'h0, in_psds, 8'h0} + {1'b0, bn};

    // one quotient bit per stage
    always_comb begin
        for (int i = 0; i < N; i++) begin
            sh[i]       = {rem_reg[i], 1'b0};
            ge[i]       = sh[i] >= {1'b0, den_reg[i]};
            rem_next[i] = ge[i] ? DW'(sh[i] - {1'b0, den_reg[i]}) : DW'(sh[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            meta_reg[0] <= in_meta;
            den_reg[0]  <= den_in;
            rem_reg[0]  <= {9'h0, in_psds, 8'h0};
            q_reg[0]    <= '0;
            zbn_reg[0]  <= (bn == '0);
            psz_reg[0]  <= (in_psds == '0);
            for (int i = 0; i < N; i++) begin
                meta_reg[i+1] <= meta_reg[i];
                den_reg[i+1]  <= den_reg[i];
                rem_reg[i+1]  <= rem_next[i];
                q_reg[i+1]    <= {q_reg[i][GAIN_W-2:0], ge[i]};
                zbn_reg[i+1]  <= zbn_reg[i];
                psz_reg[i+1]  <= psz_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= N; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int i = 0; i < N; i++) begin
                v_reg[i+1] <= v_reg[i];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_meta  = meta_reg[N];
    assign out_gain  = !zbn_reg[N] ? q_reg[N] : (psz_reg[N] ? '0 : '1);

endmodule

// ===== sv/wgbf_scale.sv =====
module wgbf_scale import wgbf_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  meta_t                   in_meta,
    input  logic [GAIN_W-1:0]       in_gain,
    output logic                    out_valid,
    output logic [BIN_W-1:0]        out_bin,
    output logic signed [SMP_W-1:0] out_re,
    output logic signed [SMP_W-1:0] out_im,
    output logic [GAIN_W-1:0]       out_gain
);

    function automatic logic signed [SMP_W-1:0] rnd_sat(logic signed [32:0] p);
        logic signed [32:0] t;
        logic signed [16:0] r;
        t = p + 33'sd32768;
        r = 17'(t >>> 16);
        if (r > 17'sd32767) begin
            return 16'sh7fff;
        end else if (r < -17'sd32768) begin
            return 16'sh8000;
        end
        return r[15:0];
    endfunction

    logic signed [32:0] pre_w, pim_w;

    logic               va_reg;
    meta_t              meta_a_reg;
    logic [GAIN_W-1:0]  g_a_reg;
    logic signed [32:0] pre_reg, pim_reg;

    logic                    vo_reg;
    logic [BIN_W-1:0]        bin_reg;
    logic signed [SMP_W-1:0] re_reg, im_reg;
    logic [GAIN_W-1:0]       gain_reg;

    assign pre_w = 33'(in_meta.tre) * 33'($signed({1'b0, in_gain}));
    assign pim_w = 33'(in_meta.tim) * 33'($signed({1'b0, in_gain}));

    always_ff @(posedge aclk) begin
        if (en) begin
            meta_a_reg <= in_meta;
            g_a_reg    <= in_gain;
            pre_reg    <= pre_w;
            pim_reg    <= pim_w;
            bin_reg    <= meta_a_reg.bin;
            if (meta_a_reg.pass) begin
                re_reg   <= meta_a_reg.tre;
                im_reg   <= meta_a_reg.tim;
                gain_reg <= '0;
            end else begin
                re_reg   <= rnd_sat(pre_reg);
                im_reg   <= rnd_sat(pim_reg);
                gain_reg <= g_a_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            va_reg <= in_valid;
            vo_reg <= va_reg;
        end
    end

    assign out_valid = vo_reg;
    assign out_bin   = bin_reg;
    assign out_re    = re_reg;
    assign out_im    = im_reg;
    assign out_gain  = gain_reg;

endmodule

// ===== sv/wiener_gain_bin_filter.sv =====
// Per-bin Wiener noise suppressor. Takes one frequency bin per item, one item per
// clock unless the result side stalls, and returns each filtered item in order after
// power tracking, gain division at one quotient bit per stage, and scaling.
// Bins may repeat or arrive in any order: same-bin updates in flight are forwarded.
// A stall on the result side holds the whole pipeline. Registers over APB at
// 0x0 alpha, 0x4 noise floor, 0x8 beta, 0xC noise update enable; write only while idle.
module wiener_gain_bin_filter import wgbf_pkg::*; #(
    parameter int HALF_FFT = HALF_FFT_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [BIN_W-1:0]        s_bin_index,
    input  logic signed [SMP_W-1:0] s_target_re,
    input  logic signed [SMP_W-1:0] s_target_im,
    input  logic signed [SMP_W-1:0] s_noise_re,
    input  logic signed [SMP_W-1:0] s_noise_im,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [BIN_W-1:0]        m_bin_out,
    output logic signed [SMP_W-1:0] m_out_re,
    output logic signed [SMP_W-1:0] m_out_im,
    output logic [GAIN_W-1:0]       m_gain_out,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [3:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic        en;
    logic        in_valid;
    meta_t       in_meta;
    cfg_t        cfg_reg;

    logic              p_valid;
    meta_t             p_meta;
    logic [PWR_W-1:0]  p_psds, p_psdn;
    logic              g_valid;
    meta_t             g_meta;
    logic [GAIN_W-1:0] g_gain;

    assign en       = !m_valid || m_ready;
    assign s_ready  = en;
    assign in_valid = s_valid && en;
    assign pready   = 1'b1;

    assign in_meta.bin  = s_bin_index;
    assign in_meta.tre  = s_target_re;
    assign in_meta.tim  = s_target_im;
    assign in_meta.pass = (s_bin_index == '0) || (32'(s_bin_index) > HALF_FFT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha <= ALPHA_RST;
            cfg_reg.floor <= FLOOR_RST;
            cfg_reg.beta  <= BETA_RST;
            cfg_reg.nue   <= NUE_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_ALPHA: cfg_reg.alpha <= pwdata[15:0];
                REG_FLOOR: cfg_reg.floor <= pwdata;
                REG_BETA:  cfg_reg.beta  <= pwdata[15:0];
                REG_NUE:   cfg_reg.nue   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ALPHA: prdata = {16'h0, cfg_reg.alpha};
            REG_FLOOR: prdata = cfg_reg.floor;
            REG_BETA:  prdata = {16'h0, cfg_reg.beta};
            REG_NUE:   prdata = {31'h0, cfg_reg.nue};
            default:   prdata = '0;
        endcase
    end

    wgbf_psd #(
        .HALF_FFT (HALF_FFT)
    ) u_psd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_valid),
        .in_meta   (in_meta),
        .in_nre    (s_noise_re),
        .in_nim    (s_noise_im),
        .cfg       (cfg_reg),
        .out_valid (p_valid),
        .out_meta  (p_meta),
        .out_psds  (p_psds),
        .out_psdn  (p_psdn)
    );

    wgbf_gain u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p_valid),
        .in_meta   (p_meta),
        .in_psds   (p_psds),
        .in_psdn   (p_psdn),
        .beta      (cfg_reg.beta),
        .out_valid (g_valid),
        .out_meta  (g_meta),
        .out_gain  (g_gain)
    );

    wgbf_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (g_valid),
        .in_meta   (g_meta),
        .in_gain   (g_gain),
        .out_valid (m_valid),
        .out_bin   (m_bin_out),
        .out_re    (m_out_re),
        .out_im    (m_out_im),
        .out_gain  (m_gain_out)
    );

    a_ready_tracks_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow output stall");

    a_bin0_no_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_bin_out == '0) |-> m_gain_out == '0)
        else $error("bin zero item carries a gain");

    a_zero_gain_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_gain_out == '0) && (m_bin_out != '0) && (32'(m_bin_out) <= HALF_FFT)
        |-> (m_out_re == '0) && (m_out_im == '0))
        else $error("zero gain with nonzero output");

    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_gain_out) && $stable(m_bin_out))
        else $error("stalled item changed");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import wgbf_pkg::*;

    class bin_scoreboard;
        logic [31:0] sig_psd [0:HALF_FFT_DEF];
        logic [31:0] nse_psd [0:HALF_FFT_DEF];
        bit          first_frame;
        logic [15:0] alpha;
        logic [31:0] floor_pwr;
        logic [15:0] beta;
        bit          nue;
        logic [BIN_W-1:0]        q_bin [$];
        logic signed [SMP_W-1:0] q_re [$];
        logic signed [SMP_W-1:0] q_im [$];
        logic [GAIN_W-1:0]       q_gain [$];
        int errors;
        int n_checked;

        function new();
            for (int i = 0; i <= HALF_FFT_DEF; i++) begin
                sig_psd[i] = 0;
                nse_psd[i] = 0;
            end
            first_frame = 1;
            alpha = ALPHA_RST;
            floor_pwr = FLOOR_RST;
            beta = BETA_RST;
            nue = NUE_RST;
            errors = 0;
            n_checked = 0;
        endfunction

        function logic [31:0] smoothed(logic [15:0] a, logic [31:0] prev, logic [31:0] curr);
            logic [63:0] s;
            s = 64'(a) * 64'(prev) + (64'd65536 - 64'(a)) * 64'(curr) + 64'd32768;
            return s[47:16];
        endfunction

        function logic signed [15:0] scaled(logic signed [15:0] x, logic [15:0] g);
            longint p;
            longint r;
            p = longint'(x) * longint'({1'b0, g}) + 32768;
            r = p >>> 16;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return 16'(r);
        endfunction

        function void note_input(logic [7:0] bin, logic signed [15:0] tre,
                                 logic signed [15:0] tim, logic signed [15:0] nre,
                                 logic signed [15:0] nim);
            logic [15:0] a;
            logic [31:0] ps, pn, cs, cn;
            logic [63:0] den, q;
            logic [15:0] g;
            q_bin = {q_bin, bin};
            if (bin == 0 || bin > HALF_FFT_DEF) begin
                q_re = {q_re, tre};
                q_im = {q_im, tim};
                q_gain = {q_gain, 16'h0};
                return;
            end
            a = first_frame ? 16'd0 : alpha;
            cs = 32'(longint'(tre) * tre + longint'(tim) * tim);
            ps = smoothed(a, sig_psd[bin], cs);
            if (nue) begin
                cn = 32'(longint'(nre) * nre + longint'(nim) * nim);
                if (cn < floor_pwr) cn = floor_pwr;
                pn = smoothed(a, nse_psd[bin], cn);
                nse_psd[bin] = pn;
            end else begin
                pn = nse_psd[bin];
            end
            sig_psd[bin] = ps;
            den = 64'(ps) * 64'd256 + 64'(beta) * 64'(pn);
            g = 0;
            if (den != 0) begin
                q = (64'(ps) << 24) / den;
                g = (q > 65535) ? 16'hFFFF : q[15:0];
            end
            q_re = {q_re, scaled(tre, g)};
            q_im = {q_im, scaled(tim, g)};
            q_gain = {q_gain, g};
            if (bin == HALF_FFT_DEF) first_frame = 0;
        endfunction

        function void check_result(logic [7:0] bin, logic signed [15:0] re,
                                   logic signed [15:0] im, logic [15:0] g);
            if (q_bin.size() == 0) begin
                $display("%0t: unexpected item bin %0d", $time, bin);
                errors++;
                return;
            end
            n_checked++;
            if (bin !== q_bin[0]) begin
                $display("%0t: bin exp %0d got %0d", $time, q_bin[0], bin);
                errors++;
            end
            if (re !== q_re[0]) begin
                $display("%0t: out_re exp %0d got %0d", $time, q_re[0], re);
                errors++;
            end
            if (im !== q_im[0]) begin
                $display("%0t: out_im exp %0d got %0d", $time, q_im[0], im);
                errors++;
            end
            if (g !== q_gain[0]) begin
                $display("%0t: gain exp %0d got %0d", $time, q_gain[0], g);
                errors++;
            end
            void'(q_bin.pop_front());
            void'(q_re.pop_front());
            void'(q_im.pop_front());
            void'(q_gain.pop_front());
        endfunction

        function int pending();
            return q_bin.size();
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [7:0] s_bin_index = 0;
    logic signed [15:0] s_target_re = 0, s_target_im = 0, s_noise_re = 0, s_noise_im = 0;
    logic m_valid;
    logic m_ready = 0;
    logic [7:0] m_bin_out;
    logic signed [15:0] m_out_re, m_out_im;
    logic [15:0] m_gain_out;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [3:0] paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic pready;

    bin_scoreboard sb = new();
    int idle_cycles = 0;
    int n_items = 0;
    bit rx_stall_mode = 0;

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    wiener_gain_bin_filter DUT (.*);

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_bin_index, s_target_re, s_target_im,
                                                  s_noise_re, s_noise_im);
            if (m_valid && m_ready) sb.check_result(m_bin_out, m_out_re, m_out_im,
                                                   m_gain_out);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > 20000) begin
                $display("wiener_gain_bin_filter verification failed");
                $finish;
            end
        end
    end

    // receiver stall pattern: alternating busy and free phases
    always @(posedge aclk) begin
        if ($urandom_range(0, 63) == 0) rx_stall_mode <= ~rx_stall_mode;
        if (rx_stall_mode) m_ready <= ($urandom_range(0, 3) != 0);
        else m_ready <= 1'b1;
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_ALPHA: sb.alpha = val[15:0];
            REG_FLOOR: sb.floor_pwr = val;
            REG_BETA:  sb.beta = val[15:0];
            default:   sb.nue = val[0];
        endcase
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic send(logic [7:0] bin, logic [15:0] tre, logic [15:0] tim,
                        logic [15:0] nre, logic [15:0] nim);
        s_valid <= 1;
        s_bin_index <= bin;
        s_target_re <= tre; s_target_im <= tim;
        s_noise_re <= nre; s_noise_im <= nim;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_items++;
    endtask

    task automatic gap();
        s_valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge aclk);
    endtask

    function automatic logic [15:0] rnd_smp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(16'($urandom_range(0, 64)) - 16'd32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_frames(int n_frames);
        int burst;
        burst = $urandom_range(1, 40);
        for (int f = 0; f < n_frames; f++) begin
            for (int b = 0; b <= HALF_FFT_DEF; b++) begin
                logic [7:0] bin;
                bin = 8'(b);
                if ($urandom_range(0, 19) == 0) bin = 8'($urandom);
                send(bin, rnd_smp(), rnd_smp(), rnd_smp(), rnd_smp());
                if (--burst == 0) begin
                    gap();
                    burst = $urandom_range(1, 40);
                end
            end
        end
        s_valid <= 0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: passthrough, out-of-range bins, zero power, extremes
        send(0, 16'h8000, 16'h7FFF, 16'h1234, 16'h0);
        send(8'd255, 16'h7FFF, 16'h8000, 16'h0, 16'h0);
        send(8'd129, 16'h0001, 16'hFFFF, 16'h0, 16'h0);
        send(1, 0, 0, 0, 0);
        send(2, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send(3, 16'h7FFF, 16'h7FFF, 0, 0);
        send(4, 0, 0, 16'h7FFF, 16'h8000);
        send(5, 16'h8000, 16'h7FFF, 16'h0010, 16'h0);
        send(5, 16'h0100, 16'hFF00, 16'h0100, 16'h0100);
        send(HALF_FFT_DEF, 16'h4000, 16'hC000, 16'h2000, 16'h2000);
        send(6, 16'h1000, 16'h1000, 16'h1000, 16'h1000);
        s_valid <= 0;
        drain();
        write_reg(REG_BETA, 0);
        write_reg(REG_FLOOR, 32'hFFFF_FFFF);
        send(6, 16'h8000, 16'h8000, 0, 0);
        send(7, 0, 0, 0, 0);
        send(8, 16'h0003, 16'h7FFF, 0, 0);
        s_valid <= 0;
        drain();
        write_reg(REG_BETA, 16'hFFFF);
        write_reg(REG_ALPHA, 16'hFFFF);
        write_reg(REG_NUE, 0);
        send(6, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
        send(9, 16'h0001, 16'h0001, 0, 0);
        s_valid <= 0;
        drain();
        write_reg(REG_FLOOR, 0);
        write_reg(REG_NUE, 1);
        write_reg(REG_ALPHA, 0);
        write_reg(REG_BETA, 256);
        random_frames(2);
        drain();
        write_reg(REG_ALPHA, 16'hFFFF);
        write_reg(REG_BETA, 16'h0080);
        write_reg(REG_FLOOR, 32'd5000);
        random_frames(2);
        drain();
        write_reg(REG_NUE, 0);
        write_reg(REG_ALPHA, 16'h8000);
        random_frames(2);
        drain();
        write_reg(REG_NUE, 1);
        write_reg(REG_ALPHA, ALPHA_RST);
        write_reg(REG_BETA, 16'h0400);
        write_reg(REG_FLOOR, 32'd0);
        random_frames(3);
        drain();
        $display("%0d items sent, %0d results checked over 7 register settings",
                 n_items, sb.n_checked);
        $display("covered passthrough, out-of-range bins, zero power, floor and frozen noise");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("wiener_gain_bin_filter verification clean");
        end else begin
            $display("wiener_gain_bin_filter verification failed");
        end
        $finish;
    end
endmodule

// ===== wiener_gain_bin_filter.f =====
sv/wgbf_pkg.sv
sv/wgbf_psd.sv
sv/wgbf_gain.sv
sv/wgbf_scale.sv
sv/wiener_gain_bin_filter.sv
test/testbench.sv
